FILE: rtl/grlex_pkg.sv
// Shared constants, mode codes and the result record for the graded-lex
// monomial stepper. No dependencies.
package grlex_pkg;

	localparam int DATA_W        = 64;
	localparam int VARS_W        = 4;
	localparam int NUM_VARS_DEF  = 8;
	localparam int EXP_BITS_DEF  = 8;
	localparam int VARS_RESET    = 8;

	localparam logic [1:0] MODE_NEXT = 2'd0;
	localparam logic [1:0] MODE_PREV = 2'd1;
	localparam logic [1:0] MODE_LT   = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] result_exponents;
		logic              result_valid;
		logic              overflow;
		logic              less_than;
	} rsp_t;

endpackage

FILE: rtl/grlex_req_if.sv
// Request channel of the graded-lex monomial stepper.
// Depends on grlex_pkg.
interface grlex_req_if;
	import grlex_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [DATA_W-1:0] exponents;
	logic [DATA_W-1:0] other_exponents;

	modport source(output valid, mode, exponents, other_exponents, input ready);
	modport sink(input valid, mode, exponents, other_exponents, output ready);
endinterface

FILE: rtl/grlex_rsp_if.sv
// Result channel of the graded-lex monomial stepper.
// Depends on grlex_pkg.
interface grlex_rsp_if;
	import grlex_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result_exponents;
	logic              result_valid;
	logic              overflow;
	logic              less_than;

	modport source(output valid, result_exponents, result_valid, overflow, less_than,
		input ready);
	modport sink(input valid, result_exponents, result_valid, overflow, less_than,
		output ready);
endinterface

FILE: rtl/grlex_core.sv
// Combinational successor / predecessor / compare datapath for one request.
// Depends on grlex_pkg.
module grlex_core #(
	parameter int NUM_VARS = grlex_pkg::NUM_VARS_DEF,
	parameter int EXP_BITS = grlex_pkg::EXP_BITS_DEF
) (
	input  logic [1:0]                  mode,
	input  logic [grlex_pkg::DATA_W-1:0] exponents,
	input  logic [grlex_pkg::DATA_W-1:0] other_exponents,
	input  logic [4:0]                  n,
	output grlex_pkg::rsp_t             rsp
);
	import grlex_pkg::*;

	localparam int FIT   = DATA_W / EXP_BITS;
	localparam int LANES = (NUM_VARS < FIT) ? NUM_VARS : FIT;
	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int N_W   = 5;
	localparam int SUM_W = EXP_BITS + 5;
	localparam logic [SUM_W-1:0] MASK = SUM_W'((1 << EXP_BITS) - 1);

	logic [EXP_BITS-1:0] a [LANES];
	logic [EXP_BITS-1:0] b [LANES];
	logic [EXP_BITS-1:0] r [LANES];
	logic [SUM_W-1:0]    da, db, d_inc, d_dec;
	logic [EXP_BITS-1:0] top, tp;
	logic [EXP_BITS:0]   inc;
	logic [IDX_W-1:0]    p, q;
	logic                ovf, lt;

	always_comb begin
		da = '0;
		db = '0;
		for (int i = 0; i < LANES; i++) begin
			a[i] = (N_W'(i) < n) ? exponents[i*EXP_BITS +: EXP_BITS] : '0;
			b[i] = (N_W'(i) < n) ? other_exponents[i*EXP_BITS +: EXP_BITS] : '0;
			da   = da + SUM_W'(a[i]);
			db   = db + SUM_W'(b[i]);
		end
		d_inc = da + SUM_W'(1);
		d_dec = da - SUM_W'(1);

		// most significant variable in use
		top = '0;
		for (int i = 0; i < LANES; i++)
			if (N_W'(i) + N_W'(1) == n) top = a[i];

		// lowest nonzero below the top variable (successor pivot)
		p = '0;
		for (int i = LANES - 2; i >= 0; i--)
			if (N_W'(i) + N_W'(1) < n && a[i] != '0) p = IDX_W'(i);
		tp = '0;
		for (int i = 0; i < LANES; i++)
			if (IDX_W'(i) == p) tp = a[i];

		// lowest nonzero above variable 0 (predecessor pivot)
		q = '0;
		for (int i = LANES - 1; i >= 1; i--)
			if (N_W'(i) < n && a[i] != '0) q = IDX_W'(i);

		// graded-lex compare: degree first, then highest differing variable
		lt = 1'b0;
		for (int i = 0; i < LANES; i++)
			if (a[i] != b[i]) lt = (a[i] < b[i]);
		if (da != db) lt = (da < db);

		ovf = 1'b0;
		inc = '0;
		for (int i = 0; i < LANES; i++) r[i] = '0;

		rsp = '0;
		case (mode)
			MODE_NEXT: begin
				if (SUM_W'(top) == da) begin
					r[0] = d_inc[EXP_BITS-1:0];
					ovf  = (d_inc > MASK);
				end else begin
					for (int i = 0; i < LANES; i++) begin
						if ((IDX_W+1)'(i) == {1'b0, p} + (IDX_W+1)'(1)) begin
							inc  = {1'b0, a[i]} + (EXP_BITS+1)'(1);
							r[i] = inc[EXP_BITS-1:0];
							ovf  = inc[EXP_BITS];
						end else if (i == 0) begin
							r[i] = tp - EXP_BITS'(1);
						end else if (IDX_W'(i) == p) begin
							r[i] = '0;
						end else begin
							r[i] = a[i];
						end
					end
				end
			end
			MODE_PREV: begin
				if (SUM_W'(a[0]) == da) begin
					for (int i = 0; i < LANES; i++)
						if (N_W'(i) + N_W'(1) == n) r[i] = d_dec[EXP_BITS-1:0];
					ovf = (d_dec > MASK);
				end else begin
					for (int i = 0; i < LANES; i++) begin
						if ((IDX_W+1)'(i) + (IDX_W+1)'(1) == {1'b0, q}) begin
							inc  = {1'b0, a[0]} + (EXP_BITS+1)'(1);
							r[i] = inc[EXP_BITS-1:0];
							ovf  = inc[EXP_BITS];
						end else if (IDX_W'(i) == q) begin
							r[i] = a[i] - EXP_BITS'(1);
						end else if (i == 0) begin
							r[i] = '0;
						end else begin
							r[i] = a[i];
						end
					end
				end
			end
			default: ;
		endcase

		case (mode)
			MODE_NEXT, MODE_PREV: begin
				if (mode == MODE_PREV && da == '0) begin
					rsp = '0;
				end else if (ovf) begin
					rsp.overflow = 1'b1;
				end else begin
					for (int i = 0; i < LANES; i++)
						rsp.result_exponents[i*EXP_BITS +: EXP_BITS] = r[i];
					rsp.result_valid = 1'b1;
				end
			end
			MODE_LT: begin
				rsp.result_valid = 1'b1;
				rsp.less_than    = lt;
			end
			default: rsp = '0;
		endcase
	end

endmodule

FILE: rtl/grlex_monomial_step.sv
// Graded-lex monomial stepper: top level with request register, datapath and result register.
// Depends on grlex_pkg, grlex_req_if, grlex_rsp_if and grlex_core.
//
// Each request carries a packed exponent vector (variable i in bits i*EXP_BITS upward,
// variable 0 least significant in lex order) and a mode: next monomial in graded-lex
// order, previous monomial, or a graded-lex less-than test against other_exponents.
// Only the low vars_in_use variables take part (clamped to 1..NUM_VARS and to the fields
// that fit in 64 bits); the rest read as zero and come back as zero. A request whose
// result exponent would not fit in EXP_BITS returns overflow=1, result_valid=0 and a zero
// vector; the previous of the constant monomial returns all zero fields; the unused mode
// code returns all zero fields. Every request produces exactly one result.
// Flow: an accepted request is captured in the input register; the single-pass datapath
// (field sum, pivot search, one increment) loads its result into the result register
// whenever that register is empty or being drained, and res.valid is its valid bit. One
// request per cycle is sustained while results are being taken; req.ready drops only
// while both registers are full and the result is not being taken. vars_in_use resets to
// 8 and may be written through cfg_we/cfg_wdata while no request is in flight.
module grlex_monomial_step #(
	parameter int NUM_VARS = grlex_pkg::NUM_VARS_DEF,
	parameter int EXP_BITS = grlex_pkg::EXP_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	grlex_req_if.sink                  req,
	grlex_rsp_if.source                res,
	input  logic                       cfg_we,
	input  logic [grlex_pkg::VARS_W-1:0] cfg_wdata
);
	import grlex_pkg::*;

	localparam int FIT   = DATA_W / EXP_BITS;
	localparam int LANES = (NUM_VARS < FIT) ? NUM_VARS : FIT;

	logic [VARS_W-1:0] vars_q;
	logic [4:0]        n_cur;

	// stage 1: captured request
	logic              valid_s1;
	logic [1:0]        mode_s1;
	logic [DATA_W-1:0] exp_s1;
	logic [DATA_W-1:0] oth_s1;
	logic [4:0]        n_s1;

	// stage 2: result register
	logic              valid_s2;
	rsp_t              rsp_s2;
	rsp_t              rsp_d;

	logic              advance;

	// clamp the active variable count to 1..LANES
	always_comb begin
		if (vars_q == '0) begin
			n_cur = 5'd1;
		end else if ({1'b0, vars_q} > 5'(LANES)) begin
			n_cur = 5'(LANES);
		end else begin
			n_cur = {1'b0, vars_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= VARS_W'(VARS_RESET);
		end else if (cfg_we) begin
			vars_q <= cfg_wdata;
		end
	end

	// result register moves when empty or being drained
	assign advance   = !valid_s2 || res.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) valid_s1 <= req.valid;
			if (advance)   valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			mode_s1 <= req.mode;
			exp_s1  <= req.exponents;
			oth_s1  <= req.other_exponents;
			n_s1    <= n_cur;
		end
		if (advance && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	grlex_core #(
		.NUM_VARS(NUM_VARS),
		.EXP_BITS(EXP_BITS)
	) u_core (
		.mode            (mode_s1),
		.exponents       (exp_s1),
		.other_exponents (oth_s1),
		.n               (n_s1),
		.rsp             (rsp_d)
	);

	assign res.valid            = valid_s2;
	assign res.result_exponents = rsp_s2.result_exponents;
	assign res.result_valid     = rsp_s2.result_valid;
	assign res.overflow         = rsp_s2.overflow;
	assign res.less_than        = rsp_s2.less_than;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for grlex_monomial_step: next, previous and less-than requests
// checked against an in-bench graded-lex predictor under random idling and backpressure.
// Depends on grlex_pkg, grlex_req_if, grlex_rsp_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
	import grlex_pkg::*;

	localparam int NUM_VARS   = NUM_VARS_DEF;
	localparam int EXP_BITS   = EXP_BITS_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;    // mode code with no meaning
	localparam int LONG_HOLD  = 64;               // receiver hold-off, in cycles
	localparam int STUCK_LIMIT = 2000;            // cycles with no handshake at all

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [VARS_W-1:0]   cfg_wdata;

	grlex_req_if req_ch();
	grlex_rsp_if res_ch();

	grlex_monomial_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow of the variable-count register; only changes while the block is empty.
	logic [VARS_W-1:0] vars_cfg = VARS_W'(VARS_RESET);
	rsp_t              expected_results[$];
	int                error_count = 0;
	bit                idle_on = 1'b1;        // random gaps on both sides
	bit                long_hold_go = 1'b0;   // asks the receiver for one long hold-off
	int                stall_left = 0;
	int                stuck_cycles = 0;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Variables taking part: register value clamped to 1..NUM_VARS and to whole
	// fields in a 64-bit word.
	function automatic int active_vars();
		int n;
		n = int'(vars_cfg);
		if (n < 1) n = 1;
		if (n > NUM_VARS) n = NUM_VARS;
		if (n > DATA_W / EXP_BITS) n = DATA_W / EXP_BITS;
		return n;
	endfunction

	// Expected result of one request. Fields at or above the active count are
	// dropped on the way in and come back as zero.
	function automatic rsp_t grlex_predict(input logic [1:0] m, input logic [DATA_W-1:0] xw,
		input logic [DATA_W-1:0] yw);
		int unsigned x[NUM_VARS];
		int unsigned y[NUM_VARS];
		int unsigned dx, dy, carry;
		int          n, i, piv;
		bit          stepped, ovf;
		rsp_t        r;

		r = '0;
		n = active_vars();
		dx = 0;
		dy = 0;
		for (i = 0; i < NUM_VARS; i++) begin
			x[i] = 0;
			y[i] = 0;
			if (i < n) begin
				x[i] = 32'(xw[i*EXP_BITS +: EXP_BITS]);
				y[i] = 32'(yw[i*EXP_BITS +: EXP_BITS]);
				dx += x[i];
				dy += y[i];
			end
		end
		stepped = 1'b0;

		case (m)
			MODE_NEXT: begin
				stepped = 1'b1;
				if (x[n-1] == dx) begin
					// all degree on the top variable: wrap to x0^(d+1)
					for (i = 0; i < n; i++) x[i] = 0;
					x[0] = dx + 1;
				end else begin
					// lowest nonzero variable below the top gives one unit upward,
					// the remainder collects in variable 0
					piv = 0;
					while (piv < n - 1 && x[piv] == 0) piv++;
					carry = x[piv] - 1;
					x[piv] = 0;
					x[piv+1] += 1;
					x[0] = carry;
				end
			end
			MODE_PREV: begin
				// constant monomial has no predecessor: all fields stay zero
				if (dx != 0) begin
					stepped = 1'b1;
					if (x[0] == dx) begin
						// everything on variable 0: drop a degree onto the top variable
						for (i = 0; i < n; i++) x[i] = 0;
						x[n-1] = dx - 1;
					end else begin
						piv = 1;
						while (piv < n - 1 && x[piv] == 0) piv++;
						carry = x[0];
						x[0] = 0;
						x[piv] -= 1;
						x[piv-1] += carry + 1;
					end
				end
			end
			MODE_LT: begin
				r.result_valid = 1'b1;
				if (dx != dy) begin
					r.less_than = (dx < dy);
				end else begin
					for (i = n - 1; i >= 0; i--) begin
						if (x[i] != y[i]) begin
							r.less_than = (x[i] < y[i]);
							break;
						end
					end
				end
			end
			default: ;
		endcase

		if (stepped) begin
			ovf = 1'b0;
			for (i = 0; i < n; i++)
				if (x[i] > (1 << EXP_BITS) - 1) ovf = 1'b1;
			if (ovf) begin
				r.overflow = 1'b1;
			end else begin
				r.result_valid = 1'b1;
				for (i = 0; i < n; i++)
					r.result_exponents[i*EXP_BITS +: EXP_BITS] = EXP_BITS'(x[i]);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offers one request and returns after the edge that accepts it. valid is
	// left high so back-to-back requests need no extra edge.
	task automatic send_request(input logic [1:0] m, input logic [DATA_W-1:0] xw,
		input logic [DATA_W-1:0] yw);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.mode            <= m;
		req_ch.exponents       <= xw;
		req_ch.other_exponents <= yw;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		expected_results.push_back(grlex_predict(m, xw, yw));
	endtask

	// Stops offering and waits for every outstanding result plus the pipe latency.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_vars_in_use(input logic [VARS_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		vars_cfg = v;
	endtask

	// Exponent vector biased toward the corner cases: many zero fields, small
	// values, values at the top of the field, and vectors with all the degree on
	// variable 0 or on the top variable. Fields above the active count get garbage.
	function automatic logic [DATA_W-1:0] random_monomial();
		logic [DATA_W-1:0]   w;
		logic [EXP_BITS-1:0] f;
		int                  n, i, shape;
		n = active_vars();
		shape = $urandom_range(0, 9);
		w = {$urandom, $urandom};
		if (shape == 0) return w;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0, 1, 2: f = '0;
				3, 4:    f = EXP_BITS'($urandom_range(1, 3));
				5:       f = {EXP_BITS{1'b1}} - EXP_BITS'($urandom_range(0, 1));
				default: f = EXP_BITS'($urandom);
			endcase
			if (shape == 1 && i != 0) f = '0;
			if (shape == 2 && i != n - 1) f = '0;
			w[i*EXP_BITS +: EXP_BITS] = f;
		end
		return w;
	endfunction

	task automatic send_random_request();
		logic [1:0]        m;
		logic [DATA_W-1:0] xw, yw;
		int                sel, i, j, n;
		sel = $urandom_range(0, 15);
		if (sel < 5) m = MODE_NEXT;
		else if (sel < 10) m = MODE_PREV;
		else if (sel < 15) m = MODE_LT;
		else m = MODE_UNUSED;
		xw = random_monomial();
		yw = random_monomial();
		if (m == MODE_LT) begin
			n = active_vars();
			case ($urandom_range(0, 2))
				0: yw = xw;   // equal vectors
				1: begin      // same degree, one unit moved between two variables
					yw = xw;
					i = $urandom_range(0, n - 1);
					j = $urandom_range(0, n - 1);
					if (yw[i*EXP_BITS +: EXP_BITS] != 0 &&
						yw[j*EXP_BITS +: EXP_BITS] != {EXP_BITS{1'b1}}) begin
						yw[i*EXP_BITS +: EXP_BITS] -= 1;
						yw[j*EXP_BITS +: EXP_BITS] += 1;
					end
				end
				default: ;
			endcase
		end
		send_request(m, xw, yw);
	endtask

	// ------------------------------------------------------------------
	// Result side: checker and ready generator
	// ------------------------------------------------------------------

	task automatic compare_field(input string fname, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
			error_count++;
		end
	endtask

	task automatic check_result();
		rsp_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with nothing expected: actual %h", $time,
				res_ch.result_exponents);
			error_count++;
		end else begin
			want = expected_results.pop_front();
			compare_field("result_exponents", want.result_exponents, res_ch.result_exponents);
			compare_field("result_valid", DATA_W'(want.result_valid),
				DATA_W'(res_ch.result_valid));
			compare_field("overflow", DATA_W'(want.overflow), DATA_W'(res_ch.overflow));
			compare_field("less_than", DATA_W'(want.less_than), DATA_W'(res_ch.less_than));
		end
	endtask

	// Outputs are read at the edge, before the block's registers move.
	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready) check_result();
		if (long_hold_go) begin
			long_hold_go = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 7);   // random-length burst
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog: any handshake on either channel restarts the count.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid === 1'b1 && res_ch.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked vectors at the reset count of eight variables.
	task automatic test_directed();
		send_request(MODE_NEXT, 64'h0, 64'h0);                    // constant -> x0
		send_request(MODE_NEXT, 64'h0500_0000_0000_0000, 64'h0);  // all on top var: wrap
		send_request(MODE_NEXT, 64'hFF00_0000_0000_0000, 64'h0);  // wrap overflows
		send_request(MODE_NEXT, 64'h0000_0000_0003_0000, 64'h0);  // pivot in the middle
		send_request(MODE_NEXT, 64'h0000_0000_0000_FF01, 64'h0);  // carry into full field
		send_request(MODE_NEXT, 64'h0000_0000_0000_00FF, 64'h0);
		send_request(MODE_NEXT, '1, '1);
		send_request(MODE_NEXT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(MODE_PREV, 64'h0, '1);                       // constant: no predecessor
		send_request(MODE_PREV, 64'h0000_0000_0000_0004, 64'h0);  // all on var 0
		send_request(MODE_PREV, 64'h0000_0000_0100_0002, 64'h0);  // borrow from var 3
		send_request(MODE_PREV, 64'h0000_0000_0000_01FF, 64'h0);  // var 0 overflows
		send_request(MODE_PREV, 64'h0100_0000_0000_0000, 64'h0);  // borrow from top var
		send_request(MODE_PREV, '1, '1);
		send_request(MODE_PREV, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(MODE_LT, 64'h0102_0304_0506_0708, 64'h0102_0304_0506_0708);
		send_request(MODE_LT, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002);
		send_request(MODE_LT, 64'h0000_0000_0000_0002, 64'h0000_0000_0000_0001);
		send_request(MODE_LT, 64'h0100_0000_0000_0000, 64'h0000_0000_0000_0001);
		send_request(MODE_LT, 64'h0000_0000_0000_0001, 64'h0100_0000_0000_0000);
		send_request(MODE_LT, '1, 64'h0);
		send_request(MODE_LT, 64'h0, '1);
		send_request(MODE_UNUSED, '1, '1);
	endtask

	// A spread of register values, including ones that clamp (0, 9, 15), with upper-field garbage.
	task automatic test_var_count_sweep();
		logic [VARS_W-1:0] counts[10];
		int                k, i;
		counts = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9};
		for (k = 0; k < 10; k++) begin
			set_vars_in_use(counts[k]);
			for (i = 0; i < 35; i++) send_random_request();
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the
	// request channel must stall once both internal registers are full.
	task automatic test_backpressure();
		int i;
		set_vars_in_use(4'd8);
		idle_on = 1'b0;
		long_hold_go = 1'b1;
		for (i = 0; i < 24; i++) send_random_request();
		idle_on = 1'b1;
	endtask

	// Sender goes quiet until the block has drained, then resumes.
	task automatic test_drain_pause();
		int i;
		for (i = 0; i < 10; i++) send_random_request();
		wait_idle();
		for (i = 0; i < 10; i++) send_random_request();
	endtask

	task automatic test_random();
		int ph, i;
		for (ph = 0; ph < 8; ph++) begin
			if (ph == 0) set_vars_in_use(4'd8);
			else if (ph == 1) set_vars_in_use(4'd1);
			else set_vars_in_use(VARS_W'($urandom_range(0, 15)));
			for (i = 0; i < 100; i++) send_random_request();
		end
		// closing stretch at full rate, no idling on either side
		set_vars_in_use(4'd8);
		idle_on = 1'b0;
		for (i = 0; i < 200; i++) send_random_request();
	endtask

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		req_ch.valid           = 1'b0;
		req_ch.mode            = MODE_NEXT;
		req_ch.exponents       = '0;
		req_ch.other_exponents = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_var_count_sweep();
		test_backpressure();
		test_drain_pause();
		test_random();

		wait_idle();
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
